// ----- hw/rtl/spsl_pkg.sv -----
// Shared types and constants of the servo pulse slew limiter.
`timescale 1ns / 1ps
`default_nettype none

package spsl_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_CENTER   = 2'd0;
   localparam logic [1:0] CSR_GAIN     = 2'd1;
   localparam logic [1:0] CSR_MAX_STEP = 2'd2;
   localparam logic [1:0] CSR_DIR_MASK = 2'd3;

   localparam logic [15:0] CENTER_RESET   = 16'd3000;
   localparam logic [7:0]  GAIN_RESET     = 8'd8;
   localparam logic [14:0] MAX_STEP_RESET = 15'd100;

   // floor(x / 50) == (x * 83887) >> 22 for every 16-bit x.
   localparam logic [16:0] RECIP_50    = 17'd83887;
   localparam int          RECIP_SHIFT = 22;

   typedef struct packed {
      logic [15:0] center_count;
      logic [7:0]  counts_per_unit;
      logic [14:0] max_step;
      logic [3:0]  dir_mask;
   } cfg_type;

   // One request after target and step have been formed.
   typedef struct packed {
      logic [1:0]  servo_index;
      logic        in_range;
      logic [15:0] target;
      logic [14:0] step;
   } item_type;

   typedef struct packed {
      logic [3:0]  lock_flags;
      logic        locked;
      logic [15:0] pulse_count;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/servo_pulse_slew_limiter_top.sv -----
// Top level of the servo pulse slew limiter: configuration registers and the two pipeline parts.
//
// Each request on req_ names one servo with its target position, offset and speed. The block
// forms the target pulse count, clips the allowed step (gain * speed / 50, at most max_step)
// and moves that servo's stored count toward the target, setting its lock bit when the
// target is reached. One response per request on rsp_: new count, lock bit, all lock flags.
// Throughput is one request per cycle while rsp_tready is high; the stored counts live in a
// one-port-read, one-port-write memory, and a write that meets a read of the same servo is
// forwarded. A request passes two arithmetic stages, the memory read stage, then the response
// register. A stalled response holds in its register while the stages before it keep filling;
// req_tready falls only when all stages are full. Reset clears the pipeline and the lock flags,
// loads the register reset values, and marks all counts as unwritten so they read as 3000; no
// clearing pass is needed. The user writes configuration through csr_we/csr_addr/csr_wdata only
// while no request is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module servo_pulse_slew_limiter_top
   import spsl_pkg::*;
#(
   parameter int NUM_SERVOS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // servo_index[1:0], goal_pos[9:2], pos_offset[17:10], speed[25:18], zero pad
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pulse_count[15:0], locked[16], lock_flags[20:17], zero pad
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   logic       mid_valid;
   logic       mid_ready;
   item_type   mid_item;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_count    <= CENTER_RESET;
         cfg_ff.counts_per_unit <= GAIN_RESET;
         cfg_ff.max_step        <= MAX_STEP_RESET;
         cfg_ff.dir_mask        <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CENTER:   cfg_ff.center_count    <= csr_wdata;
            CSR_GAIN:     cfg_ff.counts_per_unit <= csr_wdata[7:0];
            CSR_MAX_STEP: cfg_ff.max_step        <= csr_wdata[14:0];
            CSR_DIR_MASK: cfg_ff.dir_mask        <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   spsl_front #(
      .NUM_SERVOS (NUM_SERVOS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .servo_index (req_tdata[1:0]),
      .goal_pos    (req_tdata[9:2]),
      .pos_offset  (req_tdata[17:10]),
      .speed       (req_tdata[25:18]),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .out_item    (mid_item)
   );

   spsl_state #(
      .NUM_SERVOS (NUM_SERVOS)
   ) u_state (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_item    (mid_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {3'b000, result};

   // A locked response always shows at least one lock flag.
   a_lock_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.locked |-> (result.lock_flags != 4'd0))
      else $error("locked response without any lock flag");

   // The pipeline clears at reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Requests are refused only when the response side is holding a stalled response.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request refused without a stalled response");

endmodule

`default_nettype wire

// ----- hw/rtl/spsl_front.sv -----
// Front pipeline: gain products, division of the step by the frame rate, target count.
`timescale 1ns / 1ps
`default_nettype none

module spsl_front
   import spsl_pkg::*;
#(
   parameter int NUM_SERVOS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [1:0]  servo_index,
   input  wire logic [7:0]  goal_pos,
   input  wire logic [7:0]  pos_offset,
   input  wire logic [7:0]  speed,
   output logic             out_valid,
   input  wire logic        out_ready,
   output item_type         out_item
);

   logic        s1_valid_ff;
   logic [1:0]  s1_idx_ff;
   logic        s1_in_range_ff;
   logic [15:0] s1_term_ff;
   logic [15:0] s1_speed_prod_ff;
   logic        s2_valid_ff;
   item_type    s2_item_ff;
   item_type    s2_item_in;

   logic               rdy1;
   logic               rdy2;
   logic signed [8:0]  pos_sum;
   logic signed [17:0] term_prod;
   logic [15:0]        speed_prod;
   logic [32:0]        recip_prod;
   logic [10:0]        quot;
   logic [15:0]        term_signed;

   assign rdy2     = !s2_valid_ff || out_ready;
   assign rdy1     = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   assign pos_sum    = $signed({goal_pos[7], goal_pos}) + $signed({pos_offset[7], pos_offset});
   assign term_prod  = $signed({1'b0, cfg.counts_per_unit}) * pos_sum;
   assign speed_prod = cfg.counts_per_unit * speed;

   assign recip_prod = 33'(s1_speed_prod_ff) * 33'(RECIP_50);
   assign quot       = recip_prod[RECIP_SHIFT +: 11];

   // A set direction bit mirrors the position term around the center.
   assign term_signed = cfg.dir_mask[s1_idx_ff] ? (16'd0 - s1_term_ff) : s1_term_ff;

   always_comb begin
      s2_item_in.servo_index = s1_idx_ff;
      s2_item_in.in_range    = s1_in_range_ff;
      s2_item_in.target      = cfg.center_count + term_signed;
      s2_item_in.step        = ({4'd0, quot} > cfg.max_step) ? cfg.max_step : {4'd0, quot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= in_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_idx_ff        <= servo_index;
         s1_in_range_ff   <= (32'(servo_index) < NUM_SERVOS);
         s1_term_ff       <= term_prod[15:0];
         s1_speed_prod_ff <= speed_prod;
      end
      if (rdy2) s2_item_ff <= s2_item_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/spsl_state.sv -----
// Pulse count memory with read-modify-write, lock bits and the result register.
`timescale 1ns / 1ps
`default_nettype none

module spsl_state
   import spsl_pkg::*;
#(
   parameter int NUM_SERVOS = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire item_type   in_item,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_result
);

   localparam int ADDR_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam int EXT_W  = (ADDR_W > 2) ? ADDR_W : 2;

   logic [15:0]           count_mem [NUM_SERVOS];
   logic [NUM_SERVOS-1:0] written_ff;

   logic              s3_valid_ff;
   item_type          s3_item_ff;
   logic [15:0]       rd_data_ff;
   logic              rd_written_ff;
   logic              fwd_hit_ff;
   logic [15:0]       fwd_data_ff;
   logic [3:0]        lock_ff;
   logic              out_valid_ff;
   result_type        out_result_ff;

   logic              out_en;
   logic              move3;
   logic              rdy3;
   logic [EXT_W-1:0]  rd_ext;
   logic [EXT_W-1:0]  wr_ext;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   logic [15:0]       cur;
   logic [15:0]       diff;
   logic [16:0]       diff_ext;
   logic [16:0]       step_ext;
   logic [16:0]       low_sum;
   logic              go_up;
   logic              go_down;
   logic              lock;
   logic [15:0]       next_count;
   logic [3:0]        lock_in;
   result_type        result;

   assign out_en   = !out_valid_ff || out_ready;
   assign move3    = s3_valid_ff && out_en;
   assign rdy3     = !s3_valid_ff || move3;
   assign in_ready = rdy3;

   // Out-of-range servos touch nothing; their reads go to entry zero.
   assign rd_ext  = EXT_W'(in_item.servo_index);
   assign wr_ext  = EXT_W'(s3_item_ff.servo_index);
   assign rd_addr = in_item.in_range ? rd_ext[ADDR_W-1:0] : '0;
   assign wr_addr = wr_ext[ADDR_W-1:0];
   assign wr_en   = move3 && s3_item_ff.in_range;

   // A write that lands on the edge of the read is forwarded; an entry never written holds
   // the reset count.
   assign cur = fwd_hit_ff ? fwd_data_ff : (rd_written_ff ? rd_data_ff : CENTER_RESET);

   assign diff     = s3_item_ff.target - cur;
   assign diff_ext = {diff[15], diff};
   assign step_ext = {2'b00, s3_item_ff.step};
   assign low_sum  = diff_ext + step_ext;
   assign go_up    = $signed(diff_ext) > $signed(step_ext);
   assign go_down  = low_sum[16];
   assign lock     = !go_up && !go_down;

   always_comb begin
      if (go_up) begin
         next_count = cur + {1'b0, s3_item_ff.step};
      end else if (go_down) begin
         next_count = cur - {1'b0, s3_item_ff.step};
      end else begin
         next_count = s3_item_ff.target;
      end
      lock_in = lock_ff;
      lock_in[s3_item_ff.servo_index] = lock;
      if (s3_item_ff.in_range) begin
         result.pulse_count = next_count;
         result.locked      = lock;
         result.lock_flags  = lock_in;
      end else begin
         result.pulse_count = 16'd0;
         result.locked      = 1'b0;
         result.lock_flags  = lock_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) count_mem[wr_addr] <= next_count;
      if (rdy3) rd_data_ff <= count_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_item_ff    <= in_item;
         rd_written_ff <= written_ff[rd_addr];
         fwd_hit_ff    <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff   <= next_count;
      end
      if (out_en) out_result_ff <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         lock_ff      <= '0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
            lock_ff             <= lock_in;
         end
         if (rdy3) s3_valid_ff <= in_valid;
         if (out_en) out_valid_ff <= s3_valid_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

endmodule

`default_nettype wire
